[rtl/spq_pkg.sv]
// shared types and codes for the sorted priority queue
package spq_pkg;

    localparam int VALUE_W  = 32;
    localparam int RANK_W   = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 4;

    // item kinds
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // control broadcast to every cell
    typedef struct packed {
        logic                     load;
        logic                     push;
        logic signed [VALUE_W-1:0] value;
        logic [RANK_W-1:0]        rank;
    } t_cell_ctl;

endpackage

[rtl/spq_cell.sv]
// one storage cell of the sorted shift array, highest rank at cell zero
module spq_cell
    import spq_pkg::*;
(
    input  logic                      i_clk,
    input  t_cell_ctl                 i_ctl,
    input  logic                      i_valid,
    input  logic                      i_prev_ge,
    input  logic signed [VALUE_W-1:0] i_prev_value,
    input  logic [RANK_W-1:0]         i_prev_rank,
    input  logic signed [VALUE_W-1:0] i_next_value,
    input  logic [RANK_W-1:0]         i_next_rank,
    output logic                      o_ge,
    output logic signed [VALUE_W-1:0] o_value,
    output logic [RANK_W-1:0]         o_rank
);

    logic signed [VALUE_W-1:0] r_value, n_value;
    logic [RANK_W-1:0]         r_rank, n_rank;

    // entry stays ahead of the new item only if its rank is strictly larger
    assign o_ge = i_valid && (r_rank > i_ctl.rank);

    // keep, insert the new item, shift down on push, or shift up on pop
    always_comb begin
        n_value = r_value;
        n_rank  = r_rank;
        if (i_ctl.push) begin
            if (o_ge) begin
                n_value = r_value;
                n_rank  = r_rank;
            end else if (i_prev_ge) begin
                n_value = i_ctl.value;
                n_rank  = i_ctl.rank;
            end else begin
                n_value = i_prev_value;
                n_rank  = i_prev_rank;
            end
        end else begin
            n_value = i_next_value;
            n_rank  = i_next_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_value <= n_value;
            r_rank  <= n_rank;
        end
    end

    assign o_value = r_value;
    assign o_rank  = r_rank;

endmodule

[rtl/sorted_priority_queue.sv]
// sorted priority queue built as a parallel-compare shift array
// Holds up to CAPACITY value and rank pairs, highest rank first, equal ranks
// served last-in first. One item (push or pop) is taken every clock cycle:
// busy never rises. Each item's result appears on the o_ ports in the cycle
// after acceptance, marked by o_valid for exactly one cycle; the receiver
// cannot stall, so results must be captured when o_valid is high. Each item
// is handled at once by every cell comparing its rank with the new item
// in parallel and shifting one place toward or away from the top.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_kind,
    input  logic signed [VALUE_W-1:0]  i_value,
    input  logic [RANK_W-1:0]          i_rank,
    output logic                       o_valid,
    output logic [STATUS_W-1:0]        o_status,
    output logic signed [VALUE_W-1:0]  o_popped_value,
    output logic                       o_top_valid,
    output logic signed [VALUE_W-1:0]  o_top_value,
    output logic [RANK_W-1:0]          o_top_rank,
    output logic [COUNT_W-1:0]         o_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic                      w_accept;
    logic                      w_full;
    logic                      w_empty;
    t_cell_ctl                 w_ctl;
    logic [CAPACITY-1:0]       w_valid;
    logic [CAPACITY-1:0]       w_ge;
    logic signed [VALUE_W-1:0] w_value [CAPACITY];
    logic [RANK_W-1:0]         w_rank  [CAPACITY];

    logic [CW-1:0]             r_count, n_count;
    logic                      r_valid;
    logic [STATUS_W-1:0]       r_status, n_status;
    logic signed [VALUE_W-1:0] r_popped, n_popped;

    // handshake: an item every cycle
    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_empty  = (r_count == '0);

    // decode the item into cell control, status and next count
    always_comb begin
        w_ctl.load  = 1'b0;
        w_ctl.push  = (i_kind == KIND_PUSH);
        w_ctl.value = i_value;
        w_ctl.rank  = i_rank;
        n_count     = r_count;
        n_status    = ST_DONE;
        n_popped    = '0;
        if (i_kind == KIND_PUSH) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                w_ctl.load = w_accept;
                n_count    = r_count + CW'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                w_ctl.load = w_accept;
                n_count    = r_count - CW'(1);
                n_popped   = w_value[0];
            end
        end
    end

    // cell array
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic                      w_prev_ge;
            logic signed [VALUE_W-1:0] w_prev_value;
            logic [RANK_W-1:0]         w_prev_rank;
            logic signed [VALUE_W-1:0] w_next_value;
            logic [RANK_W-1:0]         w_next_rank;

            assign w_valid[gi] = (r_count > CW'(gi));

            if (gi == 0) begin : g_first
                assign w_prev_ge    = 1'b1;
                assign w_prev_value = w_value[gi];
                assign w_prev_rank  = w_rank[gi];
            end else begin : g_mid
                assign w_prev_ge    = w_ge[gi-1];
                assign w_prev_value = w_value[gi-1];
                assign w_prev_rank  = w_rank[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign w_next_value = w_value[gi];
                assign w_next_rank  = w_rank[gi];
            end else begin : g_inner
                assign w_next_value = w_value[gi+1];
                assign w_next_rank  = w_rank[gi+1];
            end

            spq_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_valid      (w_valid[gi]),
                .i_prev_ge    (w_prev_ge),
                .i_prev_value (w_prev_value),
                .i_prev_rank  (w_prev_rank),
                .i_next_value (w_next_value),
                .i_next_rank  (w_next_rank),
                .o_ge         (w_ge[gi]),
                .o_value      (w_value[gi]),
                .o_rank       (w_rank[gi])
            );
        end
    endgenerate

    // count and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_popped <= n_popped;
        end
    end

    // peek comes straight from the top cell once the item has settled
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_popped_value = r_popped;
    assign o_top_valid    = !w_empty;
    assign o_top_value    = w_empty ? '0 : w_value[0];
    assign o_top_rank     = w_empty ? '0 : w_rank[0];
    assign o_count        = COUNT_W'(r_count);

endmodule
